// ===== hw/rtl/pgalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// pgalloc_pkg
// Shared types and constants of the page allocator: request and result
// payloads, request and status codes, back-end states and default sizes.
// ----------------------------------------------------------------------------
package pgalloc_pkg;

  // Default sizes, handed down from the top level
  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths
  localparam int ADDR_W       = 22;
  localparam int END_W        = 23;
  localparam int REF_W        = 8;
  localparam int PAGE_NUM_MAX = 20;  // widest page number (largest page count)
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    REQ_FREE  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_INC   = 2'd2,
    REQ_DEC   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_TOP_INUSE = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_FULL      = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_STACK,
    BK_EXEC
  } back_state_t;

  // Request payload
  typedef struct packed {
    req_kind_t          req_type;
    logic [ADDR_W-1:0]  page_address;
  } request_t;

  // Result payload
  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  alloc_address;
    logic [REF_W-1:0]   ref_count;
    logic               page_freed;
  } result_t;

  // Classified request, as queued between front and back
  typedef struct packed {
    req_kind_t               kind;
    logic                    bad_addr;
    logic [PAGE_NUM_MAX-1:0] page;
  } item_t;

endpackage

// ===== hw/rtl/pgalloc_ram.sv =====
// ----------------------------------------------------------------------------
// pgalloc_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module pgalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pgalloc_queue.sv =====
// ----------------------------------------------------------------------------
// pgalloc_queue
// Short FIFO of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module pgalloc_queue
  import pgalloc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pgalloc_front.sv =====
// ----------------------------------------------------------------------------
// pgalloc_front
// Request front end: holds the kernel end register, accepts requests,
// checks the address and derives the page number for the queue.
// ----------------------------------------------------------------------------
module pgalloc_front
  import pgalloc_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [END_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  request_t         request,
  input  logic             queue_full,
  input  logic             clearing,
  output logic             push,
  output item_t            push_item
);

  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam logic [63:0] ADDR_LIMIT = 64'(NUM_PAGES) * 64'(PAGE_BYTES);

  logic [END_W-1:0]  kernel_end;
  logic [ADDR_W-1:0] page_full;
  logic [PAGE_W-1:0] page_num;
  logic              misaligned;
  logic              below_kernel;
  logic              above_limit;

  // Hold the kernel end register
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end <= '0;
    end else if (cfg_write) begin
      kernel_end <= cfg_data;
    end
  end

  // Classify the incoming request
  always_comb begin
    misaligned   = (request.page_address[PAGE_SH-1:0] != '0);
    below_kernel = ({1'b0, request.page_address} < kernel_end);
    above_limit  = (64'(request.page_address) >= ADDR_LIMIT);
    page_full    = ADDR_W'(request.page_address >> PAGE_SH);
    page_num     = page_full[PAGE_W-1:0];

    push_item.kind     = request.req_type;
    push_item.bad_addr = misaligned || below_kernel || above_limit;
    push_item.page     = PAGE_NUM_MAX'(page_num);
  end

  // Stall while the queue is full or the count store is being cleared
  assign in_stall = queue_full || clearing;
  assign push     = in_valid && !in_stall;

endmodule

// ===== hw/rtl/pgalloc_back.sv =====
// ----------------------------------------------------------------------------
// pgalloc_back
// Back end: clears the count store after reset, then carries out queued
// requests one at a time against the free stack and the count store, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module pgalloc_back
  import pgalloc_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  item_t   head_item,
  output logic    pop,
  output logic    clearing,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result
);

  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int TOP_W   = $clog2(NUM_PAGES + 1);
  localparam logic [PAGE_W-1:0]     LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
  localparam logic [TOP_W-1:0]      STACK_CAP = TOP_W'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  back_state_t state;
  back_state_t state_next;

  req_kind_t         cur_kind;
  logic              cur_bad;
  logic [PAGE_W-1:0] cur_page;
  logic [TOP_W-1:0]  top;
  logic [TOP_W-1:0]  top_less;
  logic [PAGE_W-1:0] clr_idx;

  // Memory ports
  logic                  stk_we;
  logic                  stk_re;
  logic [PAGE_W-1:0]     stk_raddr;
  logic [PAGE_W-1:0]     stk_rdata;
  logic                  cnt_we;
  logic [PAGE_W-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  cnt_re;
  logic [PAGE_W-1:0]     cnt_raddr;
  logic [COUNT_BITS-1:0] cnt;

  // Execute-stage decisions
  logic                  fire;
  logic                  stack_full;
  logic                  exec_cnt_we;
  logic [COUNT_BITS-1:0] exec_cnt_wdata;
  logic                  push_page;
  logic                  pop_page;
  logic [COUNT_BITS-1:0] cnt_plus;
  logic [COUNT_BITS-1:0] cnt_minus;
  logic [COUNT_BITS-1:0] ref_val;
  logic [31:0]           ref_wide;
  logic [63:0]           alloc_wide;
  result_t               res_next;

  pgalloc_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (top[PAGE_W-1:0]),
    .wdata (cur_page),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  pgalloc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_idx == LAST_PAGE) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          state_next = (head_item.kind == REQ_ALLOC) ? BK_STACK : BK_EXEC;
        end
      end
      BK_STACK: begin
        state_next = BK_EXEC;
      end
      BK_EXEC: begin
        if (!out_valid || !out_stall) begin
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  // State outputs: queue pop and memory reads
  always_comb begin
    top_less  = top - 1'b1;
    clearing  = (state == BK_CLEAR);
    pop       = (state == BK_IDLE) && head_valid;
    fire      = (state == BK_EXEC) && (!out_valid || !out_stall);
    stk_re    = pop;
    stk_raddr = top_less[PAGE_W-1:0];
    cnt_re    = pop || (state == BK_STACK);
    cnt_raddr = (state == BK_STACK) ? stk_rdata : head_item.page[PAGE_W-1:0];
  end

  // Carry out the request held in the execute stage
  always_comb begin
    stack_full     = (top == STACK_CAP);
    cnt_plus       = cnt + 1'b1;
    cnt_minus      = cnt - 1'b1;
    exec_cnt_we    = 1'b0;
    exec_cnt_wdata = cnt;
    push_page      = 1'b0;
    pop_page       = 1'b0;
    ref_val        = '0;
    alloc_wide     = 64'(cur_page) << PAGE_SH;
    res_next.status        = ST_OK;
    res_next.alloc_address = '0;
    res_next.page_freed    = 1'b0;

    if (cur_kind == REQ_ALLOC) begin
      if (top == '0) begin
        res_next.status = ST_NO_FREE;
      end else if (cnt != '0) begin
        res_next.status = ST_TOP_INUSE;
        ref_val         = cnt;
      end else begin
        exec_cnt_we            = 1'b1;
        exec_cnt_wdata         = COUNT_ONE;
        pop_page               = 1'b1;
        ref_val                = COUNT_ONE;
        res_next.alloc_address = alloc_wide[ADDR_W-1:0];
      end
    end else if (cur_bad) begin
      res_next.status = ST_BAD_ADDR;
    end else begin
      case (cur_kind)
        REQ_FREE: begin
          ref_val = cnt;
          if (stack_full) begin
            res_next.status = ST_FULL;
          end else begin
            push_page           = 1'b1;
            res_next.page_freed = 1'b1;
          end
        end
        REQ_INC: begin
          if (cnt == COUNT_MAX) begin
            res_next.status = ST_OVERFLOW;
            ref_val         = cnt;
          end else begin
            exec_cnt_we    = 1'b1;
            exec_cnt_wdata = cnt_plus;
            ref_val        = cnt_plus;
          end
        end
        default: begin
          // Decrease; the last reference frees the page
          if (cnt == '0) begin
            res_next.status = ST_UNDERFLOW;
          end else if (cnt == COUNT_ONE) begin
            if (stack_full) begin
              res_next.status = ST_FULL;
              ref_val         = cnt;
            end else begin
              exec_cnt_we         = 1'b1;
              exec_cnt_wdata      = '0;
              push_page           = 1'b1;
              res_next.page_freed = 1'b1;
            end
          end else begin
            exec_cnt_we    = 1'b1;
            exec_cnt_wdata = cnt_minus;
            ref_val        = cnt_minus;
          end
        end
      endcase
    end

    ref_wide           = 32'(ref_val);
    res_next.ref_count = ref_wide[REF_W-1:0];
  end

  // Write ports: clearing pass, otherwise the execute stage
  always_comb begin
    stk_we = fire && push_page;
    if (state == BK_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
      cnt_wdata = '0;
    end else begin
      cnt_we    = fire && exec_cnt_we;
      cnt_waddr = cur_page;
      cnt_wdata = exec_cnt_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_idx   <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (fire && push_page) begin
        top <= top + 1'b1;
      end else if (fire && pop_page) begin
        top <= top_less;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the request in flight and the result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind <= head_item.kind;
      cur_bad  <= head_item.bad_addr;
      cur_page <= head_item.page[PAGE_W-1:0];
    end else if (state == BK_STACK) begin
      cur_page <= stk_rdata;
    end
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

// ===== hw/rtl/page_allocator_with_ref_counts.sv =====
// ----------------------------------------------------------------------------
// page_allocator_with_ref_counts
// Physical page allocator with a LIFO free stack and one reference count
// per page; frees, allocations and count changes answer with one result each.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  request  | in_valid / in_stall | req_type, page_address
//  result   | out_valid/out_stall | status, alloc_address, ref_count, page_freed
//  config   | cfg_write           | cfg_data (kernel end address)
//
//  Free, increase and decrease read the count in the back end, then
//  update it; allocate first reads the stack, as the count read waits on it.
//  After rst the count store is cleared one entry a cycle, with in_stall
//  held high. A two-entry queue lets requests be taken while a result
//  waits in the output register under out_stall.
// ----------------------------------------------------------------------------
module page_allocator_with_ref_counts
  import pgalloc_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [END_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  request_t         request,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          result
);

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;
  logic  clearing;

  pgalloc_front #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .request    (request),
    .queue_full (queue_full),
    .clearing   (clearing),
    .push       (push),
    .push_item  (push_item)
  );

  pgalloc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pgalloc_back #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page allocator. A shadow copy of the free
// stack, the reference counts and the kernel end register predicts every
// result; each result transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb import pgalloc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES   = NUM_PAGES_DEF;
  localparam int PAGE_BYTES  = PAGE_BYTES_DEF;
  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int CYCLE_LIMIT = 500000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [END_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  request_t         request   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  result_t          result;

  // Shadow state of the allocator
  logic [PAGE_W-1:0]     shadow_stack [NUM_PAGES];
  int unsigned           shadow_depth;
  logic [COUNT_BITS-1:0] shadow_refs [NUM_PAGES];
  logic [END_W-1:0]      shadow_kernel_end;

  result_t     pending_results [$];
  int unsigned requests_sent    = 0;
  int unsigned results_checked  = 0;
  int unsigned mismatches       = 0;
  int unsigned settings_written = 0;
  int unsigned cycle_count      = 0;
  int unsigned status_seen [8];

  // Idling controls
  int unsigned gap_pct    = 20;
  int unsigned stall_pct  = 20;
  int unsigned stall_left = 0;
  bit          no_idling  = 1'b0;

  page_allocator_with_ref_counts i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .request   (request),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hold the whole run to a cycle budget
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (rst || no_idling) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void report_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected %0h, got %0h", field,
               results_checked, want, got);
  endfunction

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing outstanding: status %0d, address %h, count %0d",
                   result.status, result.alloc_address, result.ref_count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[result.status]++;
        if (result.status !== want.status)
          report_mismatch("status", want.status, result.status);
        if (result.alloc_address !== want.alloc_address)
          report_mismatch("alloc_address", want.alloc_address, result.alloc_address);
        if (result.ref_count !== want.ref_count)
          report_mismatch("ref_count", want.ref_count, result.ref_count);
        if (result.page_freed !== want.page_freed)
          report_mismatch("page_freed", want.page_freed, result.page_freed);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] pg);
    return ADDR_W'(pg) << PAGE_SHIFT;
  endfunction

  function automatic request_t make_request(input req_kind_t kind,
                                            input logic [ADDR_W-1:0] addr);
    request_t req;
    req.req_type     = kind;
    req.page_address = addr;
    return req;
  endfunction

  // Work out the answer to one request and advance the shadow state
  function automatic result_t apply_request(input request_t req);
    result_t               res;
    logic [PAGE_W-1:0]     pg;
    logic [COUNT_BITS-1:0] cnt;
    res        = '0;
    res.status = ST_OK;
    if (req.req_type == REQ_ALLOC) begin
      if (shadow_depth == 0) begin
        res.status = ST_NO_FREE;
        return res;
      end
      pg  = shadow_stack[PAGE_W'(shadow_depth - 1)];
      cnt = shadow_refs[pg];
      if (cnt != 0) begin
        res.status    = ST_TOP_INUSE;
        res.ref_count = REF_W'(cnt);
        return res;
      end
      shadow_refs[pg] = COUNT_BITS'(1);
      shadow_depth--;
      res.alloc_address = page_addr(pg);
      res.ref_count     = REF_W'(1);
      return res;
    end
    // Reject misaligned, kernel and out-of-range addresses
    if ((req.page_address & ADDR_W'(PAGE_BYTES - 1)) != 0 ||
        END_W'(req.page_address) < shadow_kernel_end ||
        longint'(req.page_address) >= longint'(NUM_PAGES) * PAGE_BYTES) begin
      res.status = ST_BAD_ADDR;
      return res;
    end
    pg  = PAGE_W'(req.page_address >> PAGE_SHIFT);
    cnt = shadow_refs[pg];
    case (req.req_type)
      REQ_FREE: begin
        res.ref_count = REF_W'(cnt);
        if (shadow_depth >= NUM_PAGES) begin
          res.status = ST_FULL;
        end else begin
          shadow_stack[PAGE_W'(shadow_depth)] = pg;
          shadow_depth++;
          res.page_freed = 1'b1;
        end
      end
      REQ_INC: begin
        if (cnt == COUNT_MAX) begin
          res.status    = ST_OVERFLOW;
          res.ref_count = REF_W'(cnt);
        end else begin
          shadow_refs[pg] = COUNT_BITS'(cnt + 1);
          res.ref_count   = REF_W'(cnt + 1);
        end
      end
      default: begin
        if (cnt == 0) begin
          res.status = ST_UNDERFLOW;
        end else if (cnt == 1) begin
          if (shadow_depth >= NUM_PAGES) begin
            res.status    = ST_FULL;
            res.ref_count = REF_W'(1);
          end else begin
            shadow_refs[pg]                     = '0;
            shadow_stack[PAGE_W'(shadow_depth)] = pg;
            shadow_depth++;
            res.page_freed = 1'b1;
          end
        end else begin
          shadow_refs[pg] = COUNT_BITS'(cnt - 1);
          res.ref_count   = REF_W'(cnt - 1);
        end
      end
    endcase
    return res;
  endfunction

  // Pick a page that software currently holds, from a random starting point
  function automatic bit find_held_page(output logic [PAGE_W-1:0] pg);
    int unsigned start;
    start = $urandom_range(0, NUM_PAGES - 1);
    for (int unsigned n = 0; n < NUM_PAGES; n++) begin
      pg = PAGE_W'((start + n) % NUM_PAGES);
      if (shadow_refs[pg] != 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly well-behaved software traffic, with some noise mixed in
  function automatic request_t random_request();
    int unsigned       roll;
    logic [PAGE_W-1:0] pg;
    logic [ADDR_W-1:0] noise;
    roll  = $urandom_range(0, 99);
    noise = ADDR_W'($urandom);
    if (roll >= 30 && roll < 85 && find_held_page(pg))
      return make_request(roll < 50 ? REQ_INC : REQ_DEC, page_addr(pg));
    if (roll < 85) return make_request(REQ_ALLOC, noise);
    pg = PAGE_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return make_request(req_kind_t'($urandom_range(0, 3)), noise);
      1:       return make_request(REQ_DEC, page_addr(pg));
      2:       return make_request(REQ_FREE, page_addr(pg));
      default: return make_request(REQ_INC, page_addr(pg));
    endcase
  endfunction

  task automatic pick_idling();
    gap_pct   = $urandom_range(0, 2) * 12;
    stall_pct = $urandom_range(0, 2) * 12;
  endtask

  // Send one request, after an optional gap, and hold it until the transfer
  task automatic send_request(input request_t req);
    if (!no_idling && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    request  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(req));
    requests_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_kernel_end(input logic [END_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_kernel_end = value;
    settings_written++;
    @(posedge clk);
  endtask

  // Empty stack, bad addresses, repeated free, busy top page, free on zero
  task automatic test_basic_requests();
    send_request(make_request(REQ_ALLOC, '0));
    send_request(make_request(REQ_ALLOC, '1));
    send_request(make_request(REQ_DEC, 22'h3FF000));
    send_request(make_request(REQ_FREE, 22'h3FFFFF));
    send_request(make_request(REQ_INC, 22'h000800));
    send_request(make_request(REQ_DEC, 22'h000001));
    send_request(make_request(REQ_FREE, 22'h000000));
    send_request(make_request(REQ_FREE, 22'h000000));
    send_request(make_request(REQ_ALLOC, '0));
    send_request(make_request(REQ_ALLOC, 22'h2AAAAA));
    send_request(make_request(REQ_INC, 22'h000000));
    send_request(make_request(REQ_DEC, 22'h000000));
    send_request(make_request(REQ_DEC, 22'h000000));
    send_request(make_request(REQ_FREE, 22'h3FF000));
    send_request(make_request(REQ_ALLOC, 22'h155555));
    send_request(make_request(REQ_ALLOC, '0));
    send_request(make_request(REQ_DEC, 22'h3FF000));
  endtask

  // Count up to its ceiling, one more, then step back
  task automatic test_count_saturation();
    while (shadow_refs[0] != COUNT_MAX) send_request(make_request(REQ_INC, '0));
    send_request(make_request(REQ_INC, '0));
    send_request(make_request(REQ_DEC, '0));
  endtask

  // Fill the stack with every idle page in random order, then push once more
  task automatic test_stack_full();
    int unsigned order [NUM_PAGES];
    int unsigned i, j, k, swap;
    bit          stacked;
    for (i = 0; i < NUM_PAGES; i++) order[i] = i;
    for (i = NUM_PAGES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    pick_idling();
    for (i = 0; i < NUM_PAGES && shadow_depth < NUM_PAGES; i++) begin
      stacked = 1'b0;
      for (k = 0; k < shadow_depth; k++)
        if (shadow_stack[PAGE_W'(k)] == order[i]) stacked = 1'b1;
      if (!stacked && shadow_refs[PAGE_W'(order[i])] == 0)
        send_request(make_request(REQ_FREE, page_addr(PAGE_W'(order[i]))));
    end
    send_request(make_request(REQ_FREE, page_addr(1)));
    send_request(make_request(REQ_INC, 22'h3FF000));
    send_request(make_request(REQ_DEC, 22'h3FF000));
  endtask

  // Sweep the kernel end register and probe pages either side of it
  task automatic test_kernel_end_limits();
    logic [END_W-1:0] settings [6];
    int               boundary_page;
    int unsigned      s, i;
    settings = '{23'h400000, 23'h3FFFFF, 23'h155555, 23'h2AA000, 23'h000FFF, 23'h010000};
    for (s = 0; s < 6; s++) begin
      write_kernel_end(settings[s]);
      pick_idling();
      for (i = 0; i < 50; i++) begin
        if ($urandom_range(0, 1)) begin
          boundary_page = int'(shadow_kernel_end >> PAGE_SHIFT) + $urandom_range(0, 2) - 1;
          send_request(make_request(req_kind_t'($urandom_range(0, 3)),
                                    ADDR_W'(boundary_page << PAGE_SHIFT)));
        end else begin
          send_request(random_request());
        end
      end
    end
  endtask

  // Long random run; now and then let the block drain completely
  task automatic test_random_traffic(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) pick_idling();
      if (i % 250 == 249) wait_drained();
      send_request(random_request());
    end
  endtask

  // Full rate on both channels
  task automatic test_back_to_back(input int unsigned count);
    int unsigned i;
    no_idling = 1'b1;
    for (i = 0; i < count; i++) send_request(random_request());
  endtask

  initial begin
    for (int unsigned n = 0; n < NUM_PAGES; n++) shadow_refs[PAGE_W'(n)] = '0;
    shadow_depth      = 0;
    shadow_kernel_end = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_basic_requests();
    test_count_saturation();
    test_stack_full();
    test_kernel_end_limits();
    test_random_traffic(250);
    test_back_to_back(100);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d kernel end settings, %0d mismatches",
             requests_sent, results_checked, settings_written, mismatches);
    $display("statuses: ok %0d, bad address %0d, none free %0d, top busy %0d, %s %0d, %s %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_BAD_ADDR], status_seen[ST_NO_FREE],
             status_seen[ST_TOP_INUSE], "underflow", status_seen[ST_UNDERFLOW],
             "stack full", status_seen[ST_FULL], "overflow", status_seen[ST_OVERFLOW]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pgalloc_pkg.sv
hw/rtl/pgalloc_ram.sv
hw/rtl/pgalloc_queue.sv
hw/rtl/pgalloc_front.sv
hw/rtl/pgalloc_back.sv
hw/rtl/page_allocator_with_ref_counts.sv
sim/tb.sv
